>>> hdl/idr_pkg.sv
package idr_pkg;

  localparam int unsigned FIELD_W = 64;
  localparam int unsigned OP_W    = 2;

  typedef enum logic [OP_W-1:0] {
    OP_DIV  = 2'd0,
    OP_REM  = 2'd1,
    OP_DIVU = 2'd2,
    OP_REMU = 2'd3
  } idr_op_e;

  // Per-item control that travels alongside the divider datapath
  typedef struct packed {
    logic rem_sel;
    logic neg;
    logic zero;
  } idr_ctrl_t;

endpackage

>>> hdl/idr_if.sv
interface idr_req_if;
  logic                            valid;
  logic                            ready;
  logic [idr_pkg::OP_W-1:0]        op;
  logic [idr_pkg::FIELD_W-1:0]     numerator;
  logic [idr_pkg::FIELD_W-1:0]     denominator;

  modport source (output valid, op, numerator, denominator, input ready);
  modport sink   (input valid, op, numerator, denominator, output ready);
endinterface

interface idr_rsp_if;
  logic                            valid;
  logic                            ready;
  logic [idr_pkg::FIELD_W-1:0]     result;

  modport source (output valid, result, input ready);
  modport sink   (input valid, result, output ready);
endinterface

>>> hdl/idr_step.sv
module idr_step #(
  parameter int unsigned W = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                ready_o,
  input  logic [W-1:0]        rem_i,
  input  logic [W-1:0]        quo_i,
  input  logic [W-1:0]        div_i,
  input  idr_pkg::idr_ctrl_t  ctrl_i,
  output logic                valid_o,
  input  logic                ready_i,
  output logic [W-1:0]        rem_o,
  output logic [W-1:0]        quo_o,
  output logic [W-1:0]        div_o,
  output idr_pkg::idr_ctrl_t  ctrl_o
);

  logic               valid_q;
  logic [W-1:0]       rem_q, rem_d;
  logic [W-1:0]       quo_q, quo_d;
  logic [W-1:0]       div_q;
  idr_pkg::idr_ctrl_t ctrl_q;
  logic [W:0]         shifted;
  logic [W:0]         trial;

  // One restoring step: shift in the next dividend bit, try the subtract
  always_comb begin
    shifted = {rem_i, quo_i[W-1]};
    trial   = shifted - {1'b0, div_i};
    if (trial[W]) begin
      rem_d = shifted[W-1:0];
      quo_d = {quo_i[W-2:0], 1'b0};
    end else begin
      rem_d = trial[W-1:0];
      quo_d = {quo_i[W-2:0], 1'b1};
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      rem_q  <= rem_d;
      quo_q  <= quo_d;
      div_q  <= div_i;
      ctrl_q <= ctrl_i;
    end
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign quo_o   = quo_q;
  assign div_o   = div_q;
  assign ctrl_o  = ctrl_q;

endmodule

>>> hdl/int64_divide_remainder_top.sv
// Integer divide / remainder unit, fully pipelined.
// req_i carries op (signed quotient, signed remainder, unsigned quotient,
// unsigned remainder) and two operands; rsp_o returns one result per item.
// Both channels use valid/ready; an item moves when both are high.
// Only the low DATA_WIDTH bits of the operands are used; result bits above
// DATA_WIDTH are zero. A zero divisor gives 0; signed operations truncate
// toward zero and the remainder follows the sign of the dividend.
// The input register, loaded at acceptance, takes operand magnitudes,
// DATA_WIDTH stages each retire one quotient bit with a single restoring
// subtract, and the output register applies the sign and selects quotient
// or remainder.
// Throughput: one item per cycle while the receiver takes results; the stage count sets the latency only.
// Every stage has its own valid bit and hand-off, so a stalled receiver
// holds the result in the output register while bubbles further back are
// still filled; req_i.ready falls only once the pipeline is full.
// Reset clears all valid bits; items in flight are dropped.
module int64_divide_remainder_top #(
  parameter int unsigned DATA_WIDTH = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  idr_req_if.sink    req_i,
  idr_rsp_if.source  rsp_o
);

  localparam int unsigned W = DATA_WIDTH;

  logic [W-1:0]       num, den;
  logic               is_signed, is_rem, num_neg, den_neg;
  logic [W-1:0]       num_mag, den_mag;
  idr_pkg::idr_ctrl_t ctrl_in;

  logic               prep_valid_q;
  logic [W-1:0]       prep_quo_q, prep_div_q;
  idr_pkg::idr_ctrl_t prep_ctrl_q;

  logic               valid_s [W+1];
  logic               ready_s [W+1];
  logic [W-1:0]       rem_s   [W+1];
  logic [W-1:0]       quo_s   [W+1];
  logic [W-1:0]       div_s   [W+1];
  idr_pkg::idr_ctrl_t ctrl_s  [W+1];

  logic                          out_valid_q;
  logic [idr_pkg::FIELD_W-1:0]   res_q;
  logic [W-1:0]                  sel;
  logic [W-1:0]                  fix;
  logic                          fix_load;

  // Operand magnitudes, result sign, result select and zero-divisor flag
  always_comb begin
    num       = req_i.numerator[W-1:0];
    den       = req_i.denominator[W-1:0];
    is_signed = (req_i.op == idr_pkg::OP_DIV) || (req_i.op == idr_pkg::OP_REM);
    is_rem    = (req_i.op == idr_pkg::OP_REM) || (req_i.op == idr_pkg::OP_REMU);
    num_neg   = is_signed && num[W-1];
    den_neg   = is_signed && den[W-1];
    num_mag   = num_neg ? -num : num;
    den_mag   = den_neg ? -den : den;
    ctrl_in.rem_sel = is_rem;
    ctrl_in.neg     = is_rem ? num_neg : (num_neg ^ den_neg);
    ctrl_in.zero    = (den == '0);
  end

  assign req_i.ready = !prep_valid_q || ready_s[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prep_valid_q <= 1'b0;
    end else if (req_i.ready) begin
      prep_valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      prep_quo_q  <= num_mag;
      prep_div_q  <= den_mag;
      prep_ctrl_q <= ctrl_in;
    end
  end

  assign valid_s[0] = prep_valid_q;
  assign rem_s[0]   = '0;
  assign quo_s[0]   = prep_quo_q;
  assign div_s[0]   = prep_div_q;
  assign ctrl_s[0]  = prep_ctrl_q;

  for (genvar k = 0; k < W; k++) begin : g_step
    idr_step #(
      .W (W)
    ) u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (valid_s[k]),
      .ready_o (ready_s[k]),
      .rem_i   (rem_s[k]),
      .quo_i   (quo_s[k]),
      .div_i   (div_s[k]),
      .ctrl_i  (ctrl_s[k]),
      .valid_o (valid_s[k+1]),
      .ready_i (ready_s[k+1]),
      .rem_o   (rem_s[k+1]),
      .quo_o   (quo_s[k+1]),
      .div_o   (div_s[k+1]),
      .ctrl_o  (ctrl_s[k+1])
    );
  end

  // Sign fix-up, zero-divisor result and result select
  always_comb begin
    sel = ctrl_s[W].rem_sel ? rem_s[W] : quo_s[W];
    if (ctrl_s[W].zero) begin
      fix = '0;
    end else if (ctrl_s[W].neg) begin
      fix = -sel;
    end else begin
      fix = sel;
    end
  end

  assign ready_s[W] = !out_valid_q || rsp_o.ready;
  assign fix_load   = valid_s[W] && ready_s[W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ready_s[W]) begin
      out_valid_q <= valid_s[W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (fix_load) begin
      res_q <= idr_pkg::FIELD_W'(fix);
    end
  end

  assign rsp_o.valid  = out_valid_q;
  assign rsp_o.result = res_q;

`ifndef SYNTHESIS
  a_rem_below_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_s[W] && !ctrl_s[W].zero |-> rem_s[W] < div_s[W])
    else $error("final partial remainder not below divisor");

  a_zero_div_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fix_load && ctrl_s[W].zero |=> rsp_o.result == '0)
    else $error("zero divisor did not give a zero result");

  a_last_step_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_s[W] && !ready_s[W] |=> valid_s[W] && $stable(quo_s[W]) && $stable(rem_s[W]))
    else $error("last divider stage changed while stalled");

  a_upper_bits_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> (rsp_o.result >> W) == '0)
    else $error("result bits above DATA_WIDTH are set");
`endif

endmodule

>>> test/int64_divide_remainder_top_tb.sv
module int64_divide_remainder_top_tb;

  localparam int unsigned DATA_WIDTH = 64;
  localparam int unsigned LATENCY    = DATA_WIDTH + 2;

  typedef logic [idr_pkg::FIELD_W-1:0] word_t;

  typedef struct {
    word_t             result;
    idr_pkg::idr_op_e  op;
    word_t             numerator;
    word_t             denominator;
  } division_entry_t;

  logic clk_i;
  logic rst_ni;

  idr_req_if req_if ();
  idr_rsp_if rsp_if ();

  int64_divide_remainder_top #(
    .DATA_WIDTH(DATA_WIDTH)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  division_entry_t pending_results_q[$];
  int unsigned     fail_count;
  bit              stall_free;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // Signed operations work on magnitudes and fix the sign afterwards:
  // quotient negative when signs differ, remainder follows the dividend.
  function automatic word_t predict_quotient_remainder(idr_pkg::idr_op_e op, word_t num,
                                                       word_t den);
    word_t mag_num;
    word_t mag_den;
    word_t quo;
    word_t rem;
    logic  neg_num;
    logic  neg_den;
    if (den == '0) return '0;
    if (op == idr_pkg::OP_DIVU) return num / den;
    if (op == idr_pkg::OP_REMU) return num % den;
    neg_num = num[idr_pkg::FIELD_W-1];
    neg_den = den[idr_pkg::FIELD_W-1];
    mag_num = neg_num ? word_t'(-num) : num;
    mag_den = neg_den ? word_t'(-den) : den;
    quo     = mag_num / mag_den;
    rem     = mag_num % mag_den;
    if (op == idr_pkg::OP_DIV) return (neg_num != neg_den) ? word_t'(-quo) : quo;
    return neg_num ? word_t'(-rem) : rem;
  endfunction

  // Bias operands towards small, signed-extreme and power-of-two values
  function automatic word_t pick_operand();
    word_t full;
    full = {$urandom, $urandom};
    case ($urandom_range(9))
      0:       return '0;
      4:       return word_t'($urandom_range(255));
      5:       return word_t'(-$urandom_range(255, 1));
      6:       return {32'd0, $urandom};
      7:       return word_t'(1) << $urandom_range(idr_pkg::FIELD_W - 1);
      8: begin
        case ($urandom_range(3))
          0:       return {1'b1, {(idr_pkg::FIELD_W-1){1'b0}}};
          1:       return {1'b0, {(idr_pkg::FIELD_W-1){1'b1}}};
          2:       return '1;
          default: return word_t'(1);
        endcase
      end
      9:       return full >> $urandom_range(idr_pkg::FIELD_W - 1);
      default: return full;
    endcase
  endfunction

  task automatic send_item(idr_pkg::idr_op_e op, word_t num, word_t den);
    while (!stall_free && $urandom_range(99) < 13) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid       <= 1'b1;
    req_if.op          <= op;
    req_if.numerator   <= num;
    req_if.denominator <= den;
    do @(posedge clk_i); while (!req_if.ready);
    pending_results_q.push_back('{predict_quotient_remainder(op, num, den), op, num, den});
  endtask

  // Compare on the edge where the result moves, then choose the next ready
  always @(posedge clk_i) begin
    division_entry_t entry;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (pending_results_q.size() == 0) begin
        $error("result: no item outstanding, actual %h", rsp_if.result);
        fail_count++;
      end else begin
        entry = pending_results_q.pop_front();
        if (rsp_if.result !== entry.result) begin
          $error("result mismatch (%s %h, %h): expected %h, actual %h", entry.op.name(),
                 entry.numerator, entry.denominator, entry.result, rsp_if.result);
          fail_count++;
        end
      end
    end
    rsp_if.ready <= stall_free || ($urandom_range(99) >= 13);
  end

  task automatic test_corner_cases();
    word_t most_neg;
    word_t most_pos;
    idr_pkg::idr_op_e op;
    most_neg = {1'b1, {(idr_pkg::FIELD_W-1){1'b0}}};
    most_pos = {1'b0, {(idr_pkg::FIELD_W-1){1'b1}}};
    for (int i = 0; i < 4; i++) begin
      op = idr_pkg::idr_op_e'(i);
      // zero divisor, most positive over one, most negative over minus one
      send_item(op, 64'h0123_4567_89ab_cdef, '0);
      send_item(op, most_pos, word_t'(1));
      send_item(op, most_neg, '1);
    end
    send_item(idr_pkg::OP_DIV, '0, word_t'(5));
    for (int i = 0; i < 2; i++) begin
      op = (i == 0) ? idr_pkg::OP_DIV : idr_pkg::OP_REM;
      send_item(op, word_t'(7),  word_t'(2));
      send_item(op, word_t'(-7), word_t'(2));
      send_item(op, word_t'(7),  word_t'(-2));
      send_item(op, word_t'(-7), word_t'(-2));
    end
    send_item(idr_pkg::OP_DIVU, word_t'(1), '1);
    send_item(idr_pkg::OP_REMU, word_t'(1), '1);
    send_item(idr_pkg::OP_DIVU, '1, '1);
  endtask

  task automatic test_random_operands();
    for (int n = 0; n < 1100; n++)
      send_item(idr_pkg::idr_op_e'($urandom_range(3)), pick_operand(), pick_operand());
  endtask

  task automatic test_full_rate();
    stall_free = 1'b1;
    for (int n = 0; n < 350; n++)
      send_item(idr_pkg::idr_op_e'($urandom_range(3)), pick_operand(), pick_operand());
    stall_free = 1'b0;
  endtask

  initial begin
    fail_count         = 0;
    stall_free         = 1'b0;
    rst_ni             <= 1'b0;
    req_if.valid       <= 1'b0;
    req_if.op          <= idr_pkg::OP_DIV;
    req_if.numerator   <= '0;
    req_if.denominator <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_corner_cases();
    test_random_operands();
    test_full_rate();

    req_if.valid <= 1'b0;
    while (pending_results_q.size() != 0) @(posedge clk_i);
    // catch any stray result after the last one
    repeat (LATENCY + 8) @(posedge clk_i);

    if (fail_count == 0 && pending_results_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> int64_divide_remainder_top.f
hdl/idr_pkg.sv
hdl/idr_if.sv
hdl/idr_step.sv
hdl/int64_divide_remainder_top.sv
test/int64_divide_remainder_top_tb.sv
